### hdl/lgge_pkg.sv
// Shared types and constants for the life grid generation engine.
// Used by lgge_ctrl, lgge_datapath and life_grid_generation_engine.
// No dependencies.
package lgge_pkg;

    // Default side length of the square torus grid
    localparam int GRID_SIDE = 128;

    // Command codes carried by an input transaction
    typedef enum logic [1:0] {
        CMD_TOGGLE = 2'd0,
        CMD_STEP   = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_READ   = 2'd3
    } t_command;

    // Row address sources for the grid RAM read port
    typedef enum logic [2:0] {
        RD_LAST,
        RD_FIRST,
        RD_SECOND,
        RD_AHEAD,
        RD_TARGET
    } t_rd_sel;

    // Controller to datapath command group
    typedef struct packed {
        logic    capture;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    shift;
        logic    save_first;
        logic    sweep_init;
        logic    sweep_write;
        logic    clear_all;
        logic    gen_inc;
        logic    finish;
    } t_dp_cmd;

    // Datapath to controller status group
    typedef struct packed {
        t_command cmd;
        logic     sweep_last;
    } t_dp_sts;

endpackage

### hdl/lgge_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lgge_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/lgge_datapath.sv
// Datapath of the life grid engine: row RAM, row valid bits, three-row window,
// next-generation row logic, generation counter and result registers.
// Depends on lgge_pkg and lgge_ram.
module lgge_datapath #(
    parameter int GRID_SIDE = lgge_pkg::GRID_SIDE
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lgge_pkg::t_dp_cmd i_cmd,
    output lgge_pkg::t_dp_sts o_sts,
    input  logic [1:0]        i_command,
    input  logic [6:0]        i_row,
    input  logic [6:0]        i_col,
    output logic              o_valid,
    output logic              o_cell_alive,
    output logic [31:0]       o_generation
);

    localparam int AW         = $clog2(GRID_SIDE);
    localparam int BIRTH_CNT  = 3;
    localparam int STAY_CNT   = 2;

    typedef logic [GRID_SIDE-1:0] t_row;
    typedef logic [AW-1:0]        t_idx;

    // Latched transaction
    lgge_pkg::t_command r_command;
    logic [6:0]         r_row;
    logic [6:0]         r_col;

    // Row valid bits: a row not yet written reads as all dead
    logic [GRID_SIDE-1:0] r_valid;
    logic                 r_rd_valid;
    logic                 r_use_first;

    // Sweep window and saved original first row
    t_row r_prev;
    t_row r_cur;
    t_row r_nxt;
    t_row r_first;
    t_idx r_ctr;

    logic [31:0] r_gen;
    logic        r_out_valid;
    logic        r_out_cell;
    logic [31:0] r_out_gen;

    logic [31:0] w_row_ext;
    logic [31:0] w_col_ext;
    t_idx        w_row_idx;
    t_idx        w_col_idx;
    logic        w_inside;
    logic        w_ahead_wrap;
    t_idx        w_rd_addr;
    logic        w_rd_ok;
    t_row        w_ram_q;
    t_row        w_rd_row;
    t_row        w_shift_src;
    t_row        w_next_row;
    t_row        w_toggled;
    logic        w_cell;
    logic        w_is_toggle;
    logic        w_tog_we;
    logic        w_we;
    t_idx        w_waddr;
    t_row        w_wdata;

    // Address decode of the latched transaction
    assign w_row_ext    = {25'd0, r_row};
    assign w_col_ext    = {25'd0, r_col};
    assign w_row_idx    = w_row_ext[AW-1:0];
    assign w_col_idx    = w_col_ext[AW-1:0];
    assign w_inside     = (w_row_ext < 32'(GRID_SIDE)) && (w_col_ext < 32'(GRID_SIDE));
    assign w_ahead_wrap = (r_ctr == t_idx'(GRID_SIDE - 2));
    assign w_is_toggle  = (r_command == lgge_pkg::CMD_TOGGLE);

    // Select the row to read
    always_comb begin
        case (i_cmd.rd_sel)
            lgge_pkg::RD_LAST:   w_rd_addr = t_idx'(GRID_SIDE - 1);
            lgge_pkg::RD_FIRST:  w_rd_addr = '0;
            lgge_pkg::RD_SECOND: w_rd_addr = t_idx'(1);
            lgge_pkg::RD_AHEAD:  w_rd_addr = w_ahead_wrap ? '0 : t_idx'(32'(r_ctr) + 32'd2);
            lgge_pkg::RD_TARGET: w_rd_addr = w_row_idx;
            default:             w_rd_addr = '0;
        endcase
    end

    assign w_rd_ok  = (32'(w_rd_addr) < 32'(GRID_SIDE)) ? r_valid[w_rd_addr] : 1'b0;
    assign w_rd_row = r_rd_valid ? w_ram_q : '0;
    assign w_shift_src = r_use_first ? r_first : w_rd_row;

    // Next generation of the center window row, wrapping at both ends
    always_comb begin
        logic [3:0] cnt;
        int         lf;
        int         rt;
        w_next_row = '0;
        for (int c = 0; c < GRID_SIDE; c++) begin
            lf  = (c == 0) ? GRID_SIDE - 1 : c - 1;
            rt  = (c == GRID_SIDE - 1) ? 0 : c + 1;
            cnt = 4'(r_prev[lf]) + 4'(r_prev[c]) + 4'(r_prev[rt])
                + 4'(r_cur[lf]) + 4'(r_cur[rt])
                + 4'(r_nxt[lf]) + 4'(r_nxt[c]) + 4'(r_nxt[rt]);
            w_next_row[c] = (cnt == 4'(BIRTH_CNT)) || (r_cur[c] && (cnt == 4'(STAY_CNT)));
        end
    end

    // Addressed cell and its toggled row
    assign w_cell    = w_inside ? w_rd_row[w_col_idx] : 1'b0;
    assign w_toggled = w_rd_row ^ (t_row'(1) << w_col_idx);
    assign w_tog_we  = i_cmd.finish && w_is_toggle && w_inside;

    // Share the RAM write port between sweep and toggle
    assign w_we    = i_cmd.sweep_write || w_tog_we;
    assign w_waddr = i_cmd.sweep_write ? r_ctr : w_row_idx;
    assign w_wdata = i_cmd.sweep_write ? w_next_row : w_toggled;

    lgge_ram #(
        .WIDTH (GRID_SIDE),
        .DEPTH (GRID_SIDE)
    ) u_grid_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (w_rd_addr),
        .o_rdata (w_ram_q)
    );

    // Control registers: valid bits, counter, strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_gen       <= '0;
            r_out_valid <= 1'b0;
            r_rd_valid  <= 1'b0;
            r_use_first <= 1'b0;
            r_ctr       <= '0;
        end else begin
            r_out_valid <= i_cmd.finish;
            if (i_cmd.clear_all) begin
                r_valid <= '0;
            end else if (w_we) begin
                r_valid[w_waddr] <= 1'b1;
            end
            if (i_cmd.clear_all) begin
                r_gen <= '0;
            end else if (i_cmd.gen_inc) begin
                r_gen <= r_gen + 32'd1;
            end
            if (i_cmd.rd_en) begin
                r_rd_valid  <= w_rd_ok;
                r_use_first <= (i_cmd.rd_sel == lgge_pkg::RD_AHEAD) && w_ahead_wrap;
            end
            if (i_cmd.sweep_init) begin
                r_ctr <= '0;
            end else if (i_cmd.sweep_write) begin
                r_ctr <= t_idx'(32'(r_ctr) + 32'd1);
            end
        end
    end

    // Payload registers: transaction, window, results
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_command <= lgge_pkg::t_command'(i_command);
            r_row     <= i_row;
            r_col     <= i_col;
        end
        if (i_cmd.shift) begin
            r_prev <= r_cur;
            r_cur  <= r_nxt;
            r_nxt  <= w_shift_src;
        end
        if (i_cmd.save_first) begin
            r_first <= w_rd_row;
        end
        if (i_cmd.finish) begin
            r_out_cell <= w_cell ^ (w_is_toggle && w_inside);
            r_out_gen  <= r_gen;
        end
    end

    assign o_sts.cmd        = r_command;
    assign o_sts.sweep_last = (r_ctr == t_idx'(GRID_SIDE - 1));

    assign o_valid      = r_out_valid;
    assign o_cell_alive = r_out_cell;
    assign o_generation = r_out_gen;

endmodule

### hdl/lgge_ctrl.sv
// Controller of the life grid engine: sequences command dispatch, the
// generation sweep and the final cell read. Depends on lgge_pkg.
module lgge_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  lgge_pkg::t_dp_sts i_sts,
    output lgge_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_PRE0,
        S_PRE1,
        S_LOAD,
        S_WRITE,
        S_FETCH,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;
    logic   n_busy;

    // Decode datapath commands and next state
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_sts.cmd)
                    lgge_pkg::CMD_STEP: begin
                        o_cmd.rd_en      = 1'b1;
                        o_cmd.rd_sel     = lgge_pkg::RD_LAST;
                        o_cmd.sweep_init = 1'b1;
                        n_state          = S_PRE0;
                    end
                    lgge_pkg::CMD_CLEAR: begin
                        o_cmd.clear_all = 1'b1;
                        n_state         = S_FETCH;
                    end
                    default: begin
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_sel = lgge_pkg::RD_TARGET;
                        n_state      = S_OUT;
                    end
                endcase
            end
            S_PRE0: begin
                o_cmd.shift  = 1'b1;
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = lgge_pkg::RD_FIRST;
                n_state      = S_PRE1;
            end
            S_PRE1: begin
                o_cmd.shift      = 1'b1;
                o_cmd.save_first = 1'b1;
                o_cmd.rd_en      = 1'b1;
                o_cmd.rd_sel     = lgge_pkg::RD_SECOND;
                n_state          = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.shift = 1'b1;
                n_state     = S_WRITE;
            end
            S_WRITE: begin
                o_cmd.sweep_write = 1'b1;
                if (i_sts.sweep_last) begin
                    o_cmd.gen_inc = 1'b1;
                    n_state       = S_FETCH;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = lgge_pkg::RD_AHEAD;
                    n_state      = S_LOAD;
                end
            end
            S_FETCH: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = lgge_pkg::RD_TARGET;
                n_state      = S_OUT;
            end
            S_OUT: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_busy = (n_state != S_IDLE);
    end

    // Hold state and the registered busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign busy = r_busy;

endmodule

### hdl/life_grid_generation_engine.sv
// Top level of the life grid engine (B3/S23 rule on a torus).
// Depends on lgge_pkg, lgge_ctrl, lgge_datapath and lgge_ram.
//
// Usage:
//   Command channel: drive i_command, i_row, i_col with start high; the
//   transaction is taken at a rising edge where start is high and busy is low.
//   Commands: toggle a cell, step one generation, clear the grid, read a cell.
//   Result channel: o_valid pulses for one cycle with o_cell_alive (state of
//   the addressed cell after the command) and o_generation. The receiver
//   cannot stall; every command gives exactly one result.
//   Step time is set by the sweep's two-state row loop: S_LOAD shifts the
//   window, then S_WRITE writes the new row and issues the read two rows ahead.
//   busy falls in the result cycle, so the next command can be taken then.
//   Reset (synchronous, active low) clears the per-row valid bits at once,
//   so every cell reads as dead with no clearing pass, and zeroes the
//   generation counter. Clear does the same.
module life_grid_generation_engine #(
    parameter int GRID_SIDE = lgge_pkg::GRID_SIDE
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic [6:0]  i_row,
    input  logic [6:0]  i_col,
    output logic        o_valid,
    output logic        o_cell_alive,
    output logic [31:0] o_generation
);

    lgge_pkg::t_dp_cmd w_cmd;
    lgge_pkg::t_dp_sts w_sts;

    lgge_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    lgge_datapath #(
        .GRID_SIDE (GRID_SIDE)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_command    (i_command),
        .i_row        (i_row),
        .i_col        (i_col),
        .o_valid      (o_valid),
        .o_cell_alive (o_cell_alive),
        .o_generation (o_generation)
    );

endmodule

### tb/tb.sv
// Self-checking testbench for life_grid_generation_engine (B3/S23 life on a torus).
// Predicts every command result with its own grid model; depends on lgge_pkg and life_grid_generation_engine.
`timescale 1ns / 1ps

module tb;

    localparam int SIDE          = lgge_pkg::GRID_SIDE;
    localparam int DRAIN_CYCLES  = 2 * SIDE + 16;
    localparam int TIMEOUT_NS    = 2_000_000;

    // One predicted result transaction
    typedef struct {
        bit        alive;
        bit [31:0] gen;
    } t_cell_report;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        start        = 1'b0;
    logic [1:0]  i_command    = lgge_pkg::CMD_READ;
    logic [6:0]  i_row        = '0;
    logic [6:0]  i_col        = '0;
    logic        busy;
    logic        o_valid;
    logic        o_cell_alive;
    logic [31:0] o_generation;

    // Predicted grid and generation counter
    bit          life_cells [0:SIDE-1][0:SIDE-1];
    bit          next_cells [0:SIDE-1][0:SIDE-1];
    bit [31:0]   generation_tally;

    t_cell_report pending_reports[$];
    int           error_count  = 0;
    int           items_sent   = 0;
    bit           idle_enabled = 1'b1;

    life_grid_generation_engine dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_command    (i_command),
        .i_row        (i_row),
        .i_col        (i_col),
        .o_valid      (o_valid),
        .o_cell_alive (o_cell_alive),
        .o_generation (o_generation)
    );

    // Clock: 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Compute one generation over the whole torus
    task automatic advance_life_grid();
        int up;
        int dn;
        int lf;
        int rt;
        int n;
        for (int r = 0; r < SIDE; r++) begin
            up = (r == 0) ? SIDE - 1 : r - 1;
            dn = (r == SIDE - 1) ? 0 : r + 1;
            for (int c = 0; c < SIDE; c++) begin
                lf = (c == 0) ? SIDE - 1 : c - 1;
                rt = (c == SIDE - 1) ? 0 : c + 1;
                n = life_cells[up][lf] + life_cells[up][c] + life_cells[up][rt]
                  + life_cells[r][lf] + life_cells[r][rt]
                  + life_cells[dn][lf] + life_cells[dn][c] + life_cells[dn][rt];
                if (life_cells[r][c])
                    next_cells[r][c] = (n == 2 || n == 3);
                else
                    next_cells[r][c] = (n == 3);
            end
        end
        life_cells = next_cells;
        generation_tally = generation_tally + 32'd1;
    endtask

    // Kill every cell and zero the counter
    task automatic clear_life_grid();
        for (int r = 0; r < SIDE; r++)
            for (int c = 0; c < SIDE; c++)
                life_cells[r][c] = 1'b0;
        generation_tally = '0;
    endtask

    // Apply one command to the predicted state and queue its report
    task automatic predict_cell_report(input lgge_pkg::t_command cmd, input bit [6:0] r,
                                       input bit [6:0] c);
        t_cell_report rpt;
        case (cmd)
            lgge_pkg::CMD_TOGGLE: life_cells[r][c] = ~life_cells[r][c];
            lgge_pkg::CMD_STEP:   advance_life_grid();
            lgge_pkg::CMD_CLEAR:  clear_life_grid();
            default:              ;
        endcase
        rpt.alive = life_cells[r][c];
        rpt.gen   = generation_tally;
        pending_reports.push_back(rpt);
    endtask

    // Send one command transaction; start stays high until the caller lowers it
    task automatic send_command(input lgge_pkg::t_command cmd, input bit [6:0] r,
                                input bit [6:0] c);
        if (idle_enabled && $urandom_range(0, 2) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        start     <= 1'b1;
        i_command <= cmd;
        i_row     <= r;
        i_col     <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_cell_report(cmd, r, c);
        items_sent++;
    endtask

    // Hold off the sender until every predicted report has arrived
    task automatic wait_results_drained();
        start <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
    endtask

    // Check each result transaction against the oldest prediction
    always @(posedge i_clk) begin
        t_cell_report want;
        if (i_rst_n && o_valid) begin
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected result alive=%0b generation=%0d",
                         $time, o_cell_alive, o_generation);
                error_count++;
            end else begin
                want = pending_reports.pop_front();
                if (o_cell_alive !== want.alive) begin
                    $display("%0t: cell_alive mismatch expected %0b actual %0b",
                             $time, want.alive, o_cell_alive);
                    error_count++;
                end
                if (o_generation !== want.gen) begin
                    $display("%0t: generation mismatch expected %0d actual %0d",
                             $time, want.gen, o_generation);
                    error_count++;
                end
            end
        end
    end

    // Read the extreme corners of a freshly reset grid
    task automatic test_after_reset();
        send_command(lgge_pkg::CMD_READ, 7'd0, 7'd0);
        send_command(lgge_pkg::CMD_READ, 7'd127, 7'd127);
    endtask

    // Flip each corner, then flip one back
    task automatic test_corner_toggles();
        send_command(lgge_pkg::CMD_TOGGLE, 7'd0, 7'd0);
        send_command(lgge_pkg::CMD_TOGGLE, 7'd0, 7'd127);
        send_command(lgge_pkg::CMD_TOGGLE, 7'd127, 7'd0);
        send_command(lgge_pkg::CMD_TOGGLE, 7'd127, 7'd127);
        send_command(lgge_pkg::CMD_TOGGLE, 7'd0, 7'd0);
    endtask

    // The four corners form a block through the corner wrap; it must survive
    task automatic test_corner_block();
        send_command(lgge_pkg::CMD_TOGGLE, 7'd0, 7'd0);
        send_command(lgge_pkg::CMD_STEP, 7'd127, 7'd0);
        send_command(lgge_pkg::CMD_STEP, 7'd64, 7'd64);
    endtask

    // Blinker straddling the bottom-left corner, oscillating across both edges
    task automatic test_edge_blinker();
        send_command(lgge_pkg::CMD_CLEAR, 7'd0, 7'd127);
        send_command(lgge_pkg::CMD_TOGGLE, 7'd127, 7'd127);
        send_command(lgge_pkg::CMD_TOGGLE, 7'd127, 7'd0);
        send_command(lgge_pkg::CMD_TOGGLE, 7'd127, 7'd1);
        send_command(lgge_pkg::CMD_STEP, 7'd0, 7'd0);
        send_command(lgge_pkg::CMD_READ, 7'd126, 7'd0);
        send_command(lgge_pkg::CMD_READ, 7'd127, 7'd1);
        send_command(lgge_pkg::CMD_STEP, 7'd127, 7'd1);
        send_command(lgge_pkg::CMD_READ, 7'd0, 7'd0);
    endtask

    // Seed small patterns anywhere on the torus and evolve them, mixed with noise
    task automatic test_random_patterns(input int item_goal);
        int        first_item;
        int        kind;
        bit [6:0]  anchor_r;
        bit [6:0]  anchor_c;
        first_item = items_sent;
        while (items_sent - first_item < item_goal) begin
            kind = $urandom_range(0, 9);
            if (kind < 6) begin
                anchor_r = 7'($urandom_range(0, 127));
                anchor_c = 7'($urandom_range(0, 127));
                repeat ($urandom_range(3, 8))
                    send_command(lgge_pkg::CMD_TOGGLE,
                                 anchor_r + 7'($urandom_range(0, 3)),
                                 anchor_c + 7'($urandom_range(0, 3)));
                repeat ($urandom_range(1, 3))
                    send_command(lgge_pkg::CMD_STEP,
                                 anchor_r + 7'($urandom_range(0, 3)),
                                 anchor_c + 7'($urandom_range(0, 3)));
                repeat ($urandom_range(1, 3))
                    send_command(lgge_pkg::CMD_READ,
                                 anchor_r + 7'($urandom_range(0, 4)) - 7'd1,
                                 anchor_c + 7'($urandom_range(0, 4)) - 7'd1);
            end else if (kind < 9) begin
                send_command(lgge_pkg::t_command'($urandom_range(0, 3)),
                             7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
            end else begin
                send_command(lgge_pkg::CMD_CLEAR, 7'($urandom_range(0, 127)),
                             7'($urandom_range(0, 127)));
            end
        end
    endtask

    // Run the last stretch with commands back to back
    task automatic test_back_to_back(input int item_goal);
        idle_enabled = 1'b0;
        test_random_patterns(item_goal);
    endtask

    // Run the sequence, drain, and report
    initial begin
        clear_life_grid();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_after_reset();
        test_corner_toggles();
        test_corner_block();
        wait_results_drained();
        test_edge_blinker();
        test_random_patterns(60);
        test_back_to_back(20);
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Stop a hung run
    initial begin
        #(TIMEOUT_NS);
        $display("TB_ERROR");
        $finish;
    end

endmodule
